// File: rtl/lspq_pkg.sv
package lspq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int FIFO_DEPTH = 2;
	localparam int ENTRY_W = 48;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] item_value;
		logic [15:0]        item_priority;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [15:0]        removed_priority;
		logic [4:0]         entries_held;
	} res_t;

	typedef struct packed {
		logic               op;
		logic signed [31:0] value;
		logic [15:0]        pri;
	} job_t;

	typedef struct packed {
		logic vld;
		job_t job;
	} work_t;

endpackage

// File: rtl/lspq_ram.sv
module lspq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/lspq_front.sv
module lspq_front import lspq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  cmd_t  cmd,
	output logic  busy,
	input  logic  pop,
	output work_t work
);

	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int FILL_W = $clog2(FIFO_DEPTH + 1);

	job_t              fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              push;
	job_t              job_in;

	assign busy = (fill_q == FILL_W'(FIFO_DEPTH));
	assign push = start && !busy;

	// classify the incoming word
	always_comb begin
		job_in.op    = cmd.kind ? OP_REMOVE : OP_INSERT;
		job_in.value = cmd.item_value;
		job_in.pri   = cmd.item_priority;
	end

	assign work = {(fill_q != '0), fifo_q[rd_ptr_q]};

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= job_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

endmodule

// File: rtl/lspq_back.sv
module lspq_back import lspq_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  work_t work,
	output logic  pop,
	output logic  res_strobe,
	output res_t  res
);

	localparam logic [2:0] S_IDLE       = 3'd0;
	localparam logic [2:0] S_SCAN       = 3'd1;
	localparam logic [2:0] S_SCAN_WAIT  = 3'd2;
	localparam logic [2:0] S_DECIDE     = 3'd3;
	localparam logic [2:0] S_SHIFT      = 3'd4;
	localparam logic [2:0] S_SHIFT_WAIT = 3'd5;

	logic [2:0]         state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   issue_q;
	logic               rd_vld_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	logic [IDX_W-1:0]   best_idx_q;
	logic [15:0]        best_pri_q;
	logic signed [31:0] best_val_q;
	logic               res_vld_q;
	res_t               res_q;

	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic signed [31:0] rd_value;
	logic [15:0]        rd_pri;
	logic               issuing;
	logic               last_issue;
	logic               full;
	logic               shifting;
	logic               scanning;

	assign rd_value   = ram_rdata[ENTRY_W-1:16];
	assign rd_pri     = ram_rdata[15:0];
	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign issuing    = (state_q == S_SCAN) || (state_q == S_SHIFT);
	assign shifting   = (state_q == S_SHIFT) || (state_q == S_SHIFT_WAIT);
	assign scanning   = (state_q == S_SCAN) || (state_q == S_SCAN_WAIT);
	assign last_issue = (CNT_W'(issue_q) == count_q - CNT_W'(1));

	assign pop = (state_q == S_IDLE) && work.vld;

	// append on insert, move one entry down per cycle while shifting
	assign ram_we = (pop && work.job.op == OP_INSERT && !full) || (rd_vld_s1 && shifting);
	assign ram_waddr = (state_q == S_IDLE) ? IDX_W'(count_q) : rd_idx_s1 - IDX_W'(1);
	assign ram_wdata = (state_q == S_IDLE) ? {work.job.value, work.job.pri} : ram_rdata;

	lspq_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(issue_q),
		.rdata(ram_rdata)
	);

	assign res_strobe = res_vld_q;
	assign res        = res_q;

	always_ff @(posedge clk) begin
		rd_idx_s1 <= issue_q;
		// keep the earliest entry on ties: replace only on strictly greater
		if (rd_vld_s1 && scanning) begin
			if (rd_idx_s1 == '0 || rd_pri > best_pri_q) begin
				best_idx_q <= rd_idx_s1;
				best_pri_q <= rd_pri;
				best_val_q <= rd_value;
			end
		end
		case (state_q)
			S_IDLE: begin
				if (pop) begin
					res_q.removed_value    <= '0;
					res_q.removed_priority <= '0;
					if (work.job.op == OP_INSERT) begin
						if (full) begin
							res_q.status       <= ST_FULL;
							res_q.entries_held <= 5'(count_q);
						end else begin
							res_q.status       <= ST_OK;
							res_q.entries_held <= 5'(count_q + CNT_W'(1));
						end
					end else begin
						res_q.status       <= ST_EMPTY;
						res_q.entries_held <= 5'(count_q);
					end
				end
			end
			S_DECIDE, S_SHIFT_WAIT: begin
				res_q.status           <= ST_OK;
				res_q.removed_value    <= best_val_q;
				res_q.removed_priority <= best_pri_q;
				res_q.entries_held     <= 5'(count_q - CNT_W'(1));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			issue_q   <= '0;
			rd_vld_s1 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= issuing;
			res_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (work.job.op == OP_INSERT) begin
							res_vld_q <= 1'b1;
							if (!full) begin
								count_q <= count_q + CNT_W'(1);
							end
						end else if (count_q == '0) begin
							res_vld_q <= 1'b1;
						end else begin
							issue_q <= '0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (last_issue) begin
						state_q <= S_SCAN_WAIT;
					end else begin
						issue_q <= issue_q + IDX_W'(1);
					end
				end
				S_SCAN_WAIT: begin
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					if (CNT_W'(best_idx_q) == count_q - CNT_W'(1)) begin
						count_q   <= count_q - CNT_W'(1);
						res_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						issue_q <= best_idx_q + IDX_W'(1);
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (last_issue) begin
						state_q <= S_SHIFT_WAIT;
					end else begin
						issue_q <= issue_q + IDX_W'(1);
					end
				end
				S_SHIFT_WAIT: begin
					count_q   <= count_q - CNT_W'(1);
					res_vld_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q |-> state_q == S_IDLE)
		else $error("result issued while a remove is still running");

	a_shift_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && state_q != S_IDLE) |-> (CNT_W'(ram_waddr) + CNT_W'(1) < count_q))
		else $error("shift write outside held entries");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(res_vld_q && res_q.status == ST_FULL) |-> full)
		else $error("full status with room left");
`endif

endmodule

// File: rtl/linear_scan_priority_queue_core.sv
// Bounded priority queue of (value, priority) pairs, QUEUE_DEPTH entries.
// Command channel: cmd is taken at a rising edge where start is high and busy
// is low. kind 0 appends the pair; kind 1 removes the earliest entry that
// holds the highest priority.
// Result channel: res is valid for exactly one cycle while res_strobe is
// high; one result per command, in command order. The receiver cannot stall.
// A two-word command queue sits ahead of the executing engine; busy rises
// only while that queue is full.
// With an idle engine, insert and refused commands are answered straight from
// the idle state; a remove scans every held entry and, unless the best entry
// is the last one, then moves the later entries down before its result.
// The remove cost comes from the single read port of the entry RAM: the
// scan reads one entry per cycle, then later entries move down one per cycle.
// Reset empties the queue and the command queue; entry contents are not
// cleared and are never read before being written.
module linear_scan_priority_queue_core import lspq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  cmd_t cmd,
	output logic busy,
	output logic res_strobe,
	output res_t res
);

	work_t work;
	logic  pop;

	lspq_front u_front (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.cmd   (cmd),
		.busy  (busy),
		.pop   (pop),
		.work  (work)
	);

	lspq_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.work      (work),
		.pop       (pop),
		.res_strobe(res_strobe),
		.res       (res)
	);

endmodule

// File: test/tb.sv
module tb;
	import lspq_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	cmd_t cmd = '0;
	logic busy;
	logic res_strobe;
	res_t res;

	// mirror of the queue contents, in arrival order
	logic signed [31:0] held_val [QUEUE_DEPTH];
	logic [15:0] held_pri [QUEUE_DEPTH];
	int held_cnt = 0;

	res_t due_results[$];
	int mismatches = 0;

	linear_scan_priority_queue_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.busy(busy),
		.res_strobe(res_strobe),
		.res(res)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic res_t apply_word(cmd_t c);
		res_t r;
		int best;
		r = '0;
		r.status = ST_OK;
		if (c.kind == OP_INSERT) begin
			if (held_cnt >= QUEUE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				held_val[held_cnt] = c.item_value;
				held_pri[held_cnt] = c.item_priority;
				held_cnt++;
			end
		end else if (held_cnt == 0) begin
			r.status = ST_EMPTY;
		end else begin
			// earliest entry wins a tie: only a strictly larger priority moves the pick
			best = 0;
			for (int i = 1; i < held_cnt; i++)
				if (held_pri[i] > held_pri[best])
					best = i;
			r.removed_value = held_val[best];
			r.removed_priority = held_pri[best];
			for (int i = best; i < held_cnt - 1; i++) begin
				held_val[i] = held_val[i + 1];
				held_pri[i] = held_pri[i + 1];
			end
			held_cnt--;
		end
		r.entries_held = 5'(held_cnt);
		return r;
	endfunction

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 80);
	endfunction

	// hold start high until the word is taken, then idle for the given gap
	task automatic send_word(cmd_t c, int gap);
		start <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		due_results.push_back(apply_word(c));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic cmd_t rand_word(int ins_pct, int pri_mode);
		cmd_t c;
		c.kind = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
		c.item_value = $urandom;
		case (pri_mode)
			0: c.item_priority = 16'($urandom_range(0, 3));
			1: c.item_priority = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
			default: c.item_priority = 16'($urandom);
		endcase
		return c;
	endfunction

	always @(posedge clk) begin
		res_t want;
		if (arst_n && res_strobe) begin
			if (due_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: status %0d value %0d pri %0d held %0d",
						res.status, res.removed_value, res.removed_priority,
						res.entries_held);
			end else begin
				want = due_results.pop_front();
				if (res.status !== want.status || res.removed_value !== want.removed_value ||
					res.removed_priority !== want.removed_priority ||
					res.entries_held !== want.entries_held) begin
					mismatches++;
					if (mismatches <= 10)
						$display("expected status %0d value %0d pri %0d held %0d, got %0d %0d %0d %0d",
							want.status, want.removed_value, want.removed_priority,
							want.entries_held, res.status, res.removed_value,
							res.removed_priority, res.entries_held);
				end
			end
		end
	end

	task automatic test_directed();
		logic signed [31:0] vals [16];
		logic [15:0] pris [16];
		cmd_t c;
		vals = '{32'sh80000000, 32'sh7fffffff, 32'sd0, -32'sd1, 32'sd5, 32'sd6, 32'sd7, 32'sd8,
			32'sh55555555, 32'shaaaaaaaa, 32'sd11, 32'sd12, 32'sd13, 32'sd14, 32'sd15, 32'sd16};
		pris = '{16'd5, 16'hffff, 16'd3, 16'hffff, 16'd0, 16'h8000, 16'h7fff, 16'd5,
			16'h5555, 16'haaaa, 16'd0, 16'd1, 16'hfffe, 16'd5, 16'hffff, 16'd2};
		// remove on empty queue
		c = '0;
		c.kind = OP_REMOVE;
		send_word(c, idle_len());
		// lone entry at priority zero must still come out
		c.kind = OP_INSERT;
		c.item_value = -32'sd1;
		c.item_priority = 16'd0;
		send_word(c, idle_len());
		c.kind = OP_REMOVE;
		send_word(c, idle_len());
		// fill with extremes and ties
		for (int i = 0; i < 16; i++) begin
			c.kind = OP_INSERT;
			c.item_value = vals[i];
			c.item_priority = pris[i];
			send_word(c, idle_len());
		end
		// insert into full queue
		c.item_value = 32'sh12345678;
		c.item_priority = 16'hffff;
		send_word(c, idle_len());
		for (int i = 0; i < 5; i++) begin
			c = rand_word(0, 2);
			send_word(c, idle_len());
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_random_fill_drain(int n);
		int ins_pct;
		int pri_mode;
		ins_pct = 50;
		pri_mode = 2;
		for (int i = 0; i < n; i++) begin
			// shift the insert bias now and then so the queue swings full and empty
			if (i % 40 == 0) begin
				case ($urandom_range(0, 2))
					0: ins_pct = 25;
					1: ins_pct = 50;
					default: ins_pct = 80;
				endcase
				pri_mode = $urandom_range(0, 2);
			end
			send_word(rand_word(ins_pct, pri_mode), idle_len());
		end
		start <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_back_to_back(int n);
		for (int i = 0; i < n; i++)
			send_word(rand_word(55, $urandom_range(0, 2)), 0);
		start <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random_fill_drain(1700);
		test_back_to_back(200);
		test_random_fill_drain(100);
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#2000000;
		$display("Mismatches found");
		$finish;
	end

endmodule

// File: linear_scan_priority_queue_core.f
rtl/lspq_pkg.sv
rtl/lspq_ram.sv
rtl/lspq_front.sv
rtl/lspq_back.sv
rtl/linear_scan_priority_queue_core.sv
test/tb.sv
